@@ hw/rtl/cpu_6502_subset_execute_core_macros.svh @@
// Assertion macros for the 6502 subset execute core checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CPU_6502_SUBSET_EXECUTE_CORE_MACROS_SVH
`define CPU_6502_SUBSET_EXECUTE_CORE_MACROS_SVH

// same-cycle implication, masked while in reset
`define C65X_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c65x check failed");

// next-cycle implication, masked while in reset
`define C65X_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c65x check failed");

`endif

@@ hw/rtl/c65x_pkg.sv @@
// Shared types, opcodes and constants for the 6502 subset execute core.
// No dependencies.
package c65x_pkg;

  localparam int unsigned ZP_DEPTH = 256;
  localparam int unsigned ZP_AW    = $clog2(ZP_DEPTH);

  localparam logic [15:0] RESET_START = 16'hF000;
  localparam logic [7:0]  RESET_SP    = 8'hFD;
  localparam logic [7:0]  RESET_FLAGS = 8'h34;

  // status bit positions, NV-BDIZC
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_DEY     = 8'h88;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_SEC     = 8'h38;
  localparam logic [7:0] OP_CLC     = 8'h18;
  localparam logic [7:0] OP_ASL_A   = 8'h0A;
  localparam logic [7:0] OP_AND_IMM = 8'h29;
  localparam logic [7:0] OP_ORA_IMM = 8'h09;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STA_ZPX = 8'h95;
  localparam logic [7:0] OP_STY_ZPX = 8'h94;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_BPL     = 8'h10;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_BRK     = 8'h00;

  localparam logic [1:0] STORE_NONE = 2'd0;
  localparam logic [1:0] STORE_ONE  = 2'd1;
  localparam logic [1:0] STORE_TWO  = 2'd2;

  typedef enum logic [1:0] {
    STOP_RUN = 2'd0,
    STOP_BRK = 2'd1,
    STOP_BAD = 2'd2
  } c65x_stop_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    c65x_stop_t  halt;
  } c65x_state_t;

  typedef struct packed {
    logic [1:0] count;
    logic [8:0] addr;
    logic [7:0] d1;
    logic [7:0] d2;
  } c65x_store_t;

  // update Z and N from a result byte
  function automatic logic [7:0] set_zn(input logic [7:0] flags, input logic [7:0] v);
    logic [7:0] f;
    f         = flags;
    f[FLAG_Z] = (v == 8'h00);
    f[FLAG_N] = v[7];
    return f;
  endfunction

endpackage

@@ hw/rtl/c65x_in_if.sv @@
// Instruction input channel: opcode plus the two bytes that follow it.
// Depends on nothing.
interface c65x_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand_low;
  logic [7:0] operand_high;

  modport source (output valid, output opcode, output operand_low, output operand_high,
                  input ready);
  modport sink   (input valid, input opcode, input operand_low, input operand_high,
                  output ready);
endinterface

@@ hw/rtl/c65x_out_if.sv @@
// Result channel: register file snapshot, memory writes and stop code.
// Depends on nothing.
interface c65x_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  sp_out;
  logic [7:0]  flags_out;
  logic [1:0]  store_count;
  logic [8:0]  store_address;
  logic [7:0]  store_first_data;
  logic [7:0]  store_second_data;
  logic [1:0]  stop_code;

  modport source (output valid, output next_pc, output acc_out, output x_out, output y_out,
                  output sp_out, output flags_out, output store_count, output store_address,
                  output store_first_data, output store_second_data, output stop_code,
                  input ready);
  modport sink   (input valid, input next_pc, input acc_out, input x_out, input y_out,
                  input sp_out, input flags_out, input store_count, input store_address,
                  input store_first_data, input store_second_data, input stop_code,
                  output ready);
endinterface

@@ hw/rtl/c65x_exec.sv @@
// Combinational instruction execute: decodes one opcode and computes the next
// architectural state and the memory writes. Depends on c65x_pkg.
module c65x_exec import c65x_pkg::*; (
  input  c65x_state_t st,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand_low,
  input  logic [7:0]  operand_high,
  input  logic [7:0]  zp_data,
  output c65x_state_t st_nxt,
  output c65x_store_t sto
);

  logic [15:0] pc1;
  logic [15:0] pc2;
  logic [15:0] br_target;
  logic [7:0]  add_m;
  logic [8:0]  add_sum;
  logic [7:0]  add_r;
  logic [7:0]  x_inc;
  logic [7:0]  x_dec;
  logic [7:0]  y_inc;
  logic [7:0]  y_dec;
  logic [7:0]  asl_r;
  logic [7:0]  and_r;
  logic [7:0]  ora_r;
  logic [7:0]  zpx_addr;

  assign pc1       = st.pc + 16'd1;
  assign pc2       = st.pc + 16'd2;
  assign br_target = pc2 + {{8{operand_low[7]}}, operand_low};

  // SBC is ADC of the inverted operand
  assign add_m   = (opcode == OP_SBC_IMM) ? ~operand_low : operand_low;
  assign add_sum = {1'b0, st.a} + {1'b0, add_m} + {8'd0, st.p[FLAG_C]};
  assign add_r   = add_sum[7:0];

  assign x_inc    = st.x + 8'd1;
  assign x_dec    = st.x - 8'd1;
  assign y_inc    = st.y + 8'd1;
  assign y_dec    = st.y - 8'd1;
  assign asl_r    = {st.a[6:0], 1'b0};
  assign and_r    = st.a & operand_low;
  assign ora_r    = st.a | operand_low;
  assign zpx_addr = operand_low + st.x;

  always_comb begin
    st_nxt    = st;
    st_nxt.pc = pc2;
    sto       = '0;
    case (opcode)
      OP_LDA_IMM: begin
        st_nxt.a = operand_low;
        st_nxt.p = set_zn(st.p, operand_low);
      end
      OP_LDA_ZP: begin
        st_nxt.a = zp_data;
        st_nxt.p = set_zn(st.p, zp_data);
      end
      OP_LDX_IMM: begin
        st_nxt.x = operand_low;
        st_nxt.p = set_zn(st.p, operand_low);
      end
      OP_LDY_IMM: begin
        st_nxt.y = operand_low;
        st_nxt.p = set_zn(st.p, operand_low);
      end
      OP_TAX: begin
        st_nxt.x  = st.a;
        st_nxt.p  = set_zn(st.p, st.a);
        st_nxt.pc = pc1;
      end
      OP_TXA: begin
        st_nxt.a  = st.x;
        st_nxt.p  = set_zn(st.p, st.x);
        st_nxt.pc = pc1;
      end
      OP_TXS: begin
        st_nxt.sp = st.x;
        st_nxt.pc = pc1;
      end
      OP_INX: begin
        st_nxt.x  = x_inc;
        st_nxt.p  = set_zn(st.p, x_inc);
        st_nxt.pc = pc1;
      end
      OP_INY: begin
        st_nxt.y  = y_inc;
        st_nxt.p  = set_zn(st.p, y_inc);
        st_nxt.pc = pc1;
      end
      OP_DEX: begin
        st_nxt.x  = x_dec;
        st_nxt.p  = set_zn(st.p, x_dec);
        st_nxt.pc = pc1;
      end
      OP_DEY: begin
        st_nxt.y  = y_dec;
        st_nxt.p  = set_zn(st.p, y_dec);
        st_nxt.pc = pc1;
      end
      OP_CLD: begin
        st_nxt.p[FLAG_D] = 1'b0;
        st_nxt.pc        = pc1;
      end
      OP_SEI: begin
        st_nxt.p[FLAG_I] = 1'b1;
        st_nxt.pc        = pc1;
      end
      OP_SEC: begin
        st_nxt.p[FLAG_C] = 1'b1;
        st_nxt.pc        = pc1;
      end
      OP_CLC: begin
        st_nxt.p[FLAG_C] = 1'b0;
        st_nxt.pc        = pc1;
      end
      OP_ASL_A: begin
        st_nxt.a         = asl_r;
        st_nxt.p         = set_zn(st.p, asl_r);
        st_nxt.p[FLAG_C] = st.a[7];
        st_nxt.pc        = pc1;
      end
      OP_AND_IMM: begin
        st_nxt.a = and_r;
        st_nxt.p = set_zn(st.p, and_r);
      end
      OP_ORA_IMM: begin
        st_nxt.a = ora_r;
        st_nxt.p = set_zn(st.p, ora_r);
      end
      OP_ADC_IMM, OP_SBC_IMM: begin
        st_nxt.a         = add_r;
        st_nxt.p         = set_zn(st.p, add_r);
        st_nxt.p[FLAG_C] = add_sum[8];
        st_nxt.p[FLAG_V] = ~(st.a[7] ^ add_m[7]) & (st.a[7] ^ add_r[7]);
      end
      OP_STA_ZP: begin
        sto.count = STORE_ONE;
        sto.addr  = {1'b0, operand_low};
        sto.d1    = st.a;
      end
      OP_STX_ZP: begin
        sto.count = STORE_ONE;
        sto.addr  = {1'b0, operand_low};
        sto.d1    = st.x;
      end
      OP_STA_ZPX: begin
        sto.count = STORE_ONE;
        sto.addr  = {1'b0, zpx_addr};
        sto.d1    = st.a;
      end
      OP_STY_ZPX: begin
        sto.count = STORE_ONE;
        sto.addr  = {1'b0, zpx_addr};
        sto.d1    = st.y;
      end
      OP_BNE: begin
        if (!st.p[FLAG_Z]) begin
          st_nxt.pc = br_target;
        end
      end
      OP_BPL: begin
        if (!st.p[FLAG_N]) begin
          st_nxt.pc = br_target;
        end
      end
      OP_JSR: begin
        // return address is the last byte of the JSR, high byte pushed first
        sto.count = STORE_TWO;
        sto.addr  = {1'b1, st.sp};
        sto.d1    = pc2[15:8];
        sto.d2    = pc2[7:0];
        st_nxt.sp = st.sp - 8'd2;
        st_nxt.pc = {operand_high, operand_low};
      end
      OP_BRK: begin
        st_nxt      = st;
        st_nxt.halt = STOP_BRK;
      end
      default: begin
        st_nxt      = st;
        st_nxt.halt = STOP_BAD;
      end
    endcase
    // once halted, instructions are absorbed with no effect
    if (st.halt != STOP_RUN) begin
      st_nxt = st;
      sto    = '0;
    end
  end

endmodule

@@ hw/rtl/cpu_6502_subset_execute_core.sv @@
// 6502 subset execute core. Each input beat carries one instruction (opcode and the two
// bytes after it at the current PC); each produces exactly one result beat with the
// register file after the instruction, up to two memory writes and a stop code. Throughput
// is one instruction per clock while the result channel is not stalled; each beat passes
// the input register (where the registered zero-page RAM read is taken) and then the result
// register. A/X/Y/SP/P/PC are kept inside; the PC is not taken from the input. The 256-byte
// zero-page RAM has a valid bit per entry, so it reads as zero after reset with no clearing
// pass. Writing cfg_wr_data loads the PC directly; do so only while the core is idle. BRK
// or an undefined opcode halts the core until reset; later beats return the held state.
// Depends on c65x_pkg, c65x_in_if, c65x_out_if and c65x_exec.
module cpu_6502_subset_execute_core import c65x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  c65x_in_if.sink     in_chan,
  c65x_out_if.source  out_chan
);

  // architectural state
  c65x_state_t st_r;
  c65x_state_t st_nxt;
  c65x_store_t sto;

  // input stage
  logic        s1_vld_r;
  logic [7:0]  s1_op_r;
  logic [7:0]  s1_lo_r;
  logic [7:0]  s1_hi_r;

  // zero-page RAM and its read path
  logic [7:0]          zp_mem [ZP_DEPTH];
  logic [ZP_DEPTH-1:0] zp_vld_r;
  logic [7:0]          rd_data_r;
  logic                rd_vld_r;
  logic                byp_r;
  logic [7:0]          byp_data_r;
  logic [7:0]          zp_data;
  logic                zp_we;
  logic [ZP_AW-1:0]    zp_wa;

  // result stage
  logic        out_vld_r;
  c65x_state_t out_st_r;
  c65x_store_t out_sto_r;

  logic in_fire;
  logic ex_fire;

  assign ex_fire       = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !s1_vld_r || ex_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  c65x_exec u_exec (
    .st           (st_r),
    .opcode       (s1_op_r),
    .operand_low  (s1_lo_r),
    .operand_high (s1_hi_r),
    .zp_data      (zp_data),
    .st_nxt       (st_nxt),
    .sto          (sto)
  );

  assign zp_we = ex_fire && (sto.count == STORE_ONE);
  assign zp_wa = sto.addr[ZP_AW-1:0];

  // a store retiring on the same edge as the read wins over the old RAM word
  assign zp_data = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : 8'h00);

  always_ff @(posedge clk) begin
    if (zp_we) begin
      zp_mem[zp_wa] <= sto.d1;
    end
    if (in_fire) begin
      rd_data_r  <= zp_mem[in_chan.operand_low];
      byp_data_r <= sto.d1;
      s1_op_r    <= in_chan.opcode;
      s1_lo_r    <= in_chan.operand_low;
      s1_hi_r    <= in_chan.operand_high;
    end
    if (ex_fire) begin
      out_st_r  <= st_nxt;
      out_sto_r <= sto;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_vld_r <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (zp_we) begin
        zp_vld_r[zp_wa] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_r <= zp_vld_r[in_chan.operand_low];
        byp_r    <= zp_we && (zp_wa == in_chan.operand_low);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r.pc   <= RESET_START;
      st_r.a    <= 8'h00;
      st_r.x    <= 8'h00;
      st_r.y    <= 8'h00;
      st_r.sp   <= RESET_SP;
      st_r.p    <= RESET_FLAGS;
      st_r.halt <= STOP_RUN;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (ex_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (ex_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (ex_fire) begin
        st_r <= st_nxt;
      end else if (cfg_wr_en) begin
        st_r.pc <= cfg_wr_data;
      end
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.next_pc           = out_st_r.pc;
  assign out_chan.acc_out           = out_st_r.a;
  assign out_chan.x_out             = out_st_r.x;
  assign out_chan.y_out             = out_st_r.y;
  assign out_chan.sp_out            = out_st_r.sp;
  assign out_chan.flags_out         = out_st_r.p;
  assign out_chan.store_count       = out_sto_r.count;
  assign out_chan.store_address     = out_sto_r.addr;
  assign out_chan.store_first_data  = out_sto_r.d1;
  assign out_chan.store_second_data = out_sto_r.d2;
  assign out_chan.stop_code         = out_st_r.halt;

endmodule

@@ hw/rtl/c65x_chk.sv @@
// Port-level checker for the 6502 subset execute core, bound to the top level.
// Depends on c65x_pkg and cpu_6502_subset_execute_core_macros.svh.
`include "cpu_6502_subset_execute_core_macros.svh"

module c65x_chk import c65x_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] next_pc,
  input logic [1:0]  store_count,
  input logic [8:0]  store_address,
  input logic [7:0]  store_first_data,
  input logic [7:0]  store_second_data,
  input logic [1:0]  stop_code
);

  logic stopped;
  logic wr_any;
  logic wr_two;
  logic wr_clear;

  assign stopped  = (stop_code != STOP_RUN);
  assign wr_any   = (store_count != STORE_NONE);
  assign wr_two   = (store_count == STORE_TWO);
  assign wr_clear = (store_address == 9'd0) && (store_first_data == 8'd0) &&
                    (store_second_data == 8'd0);

  // a stalled result beat keeps its PC
  `C65X_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_pc))

  // a halted core never writes memory
  `C65X_ASSERT_NOW(a_halt_no_store, out_valid && stopped, !wr_any)

  // unused write fields read as zero
  `C65X_ASSERT_NOW(a_no_store_zero, out_valid && !wr_any, wr_clear)

  // zero-page stores stay in page 0, JSR pushes land in page 1
  `C65X_ASSERT_NOW(a_store_page, out_valid && wr_any, store_address[8] == wr_two)

endmodule

bind cpu_6502_subset_execute_core c65x_chk u_c65x_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .next_pc           (out_chan.next_pc),
  .store_count       (out_chan.store_count),
  .store_address     (out_chan.store_address),
  .store_first_data  (out_chan.store_first_data),
  .store_second_data (out_chan.store_second_data),
  .stop_code         (out_chan.stop_code)
);
